FILE: design/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under active-low reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication under active-low reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/ppd_pkg.sv
// types, constants and helpers for the palette pixel decoder
package ppd_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 24;
  localparam int ALPHA_W = 8;
  localparam int RGBA_W  = 32;
  localparam int CNT_W   = 3;
  localparam int MODE_W  = 2;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_NONE = 8'h00;
  localparam logic [CNT_W-1:0]   CNT_LAST   = 3'd7;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPAQUE = 2'd0,
    MODE_BIT    = 2'd1,
    MODE_BYTE   = 2'd2
  } alpha_mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ALPHA_MODE = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic               opcode;
    logic [IDX_W-1:0]   palette_index;
    logic [COLOR_W-1:0] palette_color;
    logic [ALPHA_W-1:0] alpha_byte;
    logic               first_pixel;
  } in_word_t;

  typedef struct packed {
    logic [RGBA_W-1:0] rgba;
    logic              advance_alpha;
  } out_word_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               advance;
  } alpha_info_t;

  // stored order is red high, blue low; output wants red low
  function automatic logic [COLOR_W-1:0] swap_rb(input logic [COLOR_W-1:0] c);
    swap_rb = {c[7:0], c[15:8], c[23:16]};
  endfunction

endpackage

FILE: design/ppd_ram.sv
// generic single-port-write, registered-read ram
module ppd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ppd_cfg_regs.sv
// apb register block holding the alpha mode
module ppd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppd_pkg::APB_AW-1:0]  paddr,
  input  logic [ppd_pkg::APB_DW-1:0]  pwdata,
  output logic [ppd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output ppd_pkg::alpha_mode_e        alpha_mode_o
);

  ppd_pkg::alpha_mode_e mode_q, mode_d;
  logic [ppd_pkg::REG_IDX_W-1:0] reg_idx;
  logic hit;

  assign reg_idx = paddr[ppd_pkg::APB_AW-1:2];
  assign hit     = (reg_idx == ppd_pkg::REG_ALPHA_MODE);

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && hit) begin
      mode_d = ppd_pkg::alpha_mode_e'(pwdata[ppd_pkg::MODE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ppd_pkg::MODE_OPAQUE;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign prdata = hit ? {{(ppd_pkg::APB_DW-ppd_pkg::MODE_W){1'b0}}, mode_q}
                      : '0;
  assign pready = 1'b1;
  assign alpha_mode_o = mode_q;

endmodule

FILE: design/ppd_alpha_gen.sv
// alpha selection and packed-bit counter
module ppd_alpha_gen (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pixel_fire_i,
  input  logic                         first_pixel_i,
  input  logic [ppd_pkg::ALPHA_W-1:0]  alpha_byte_i,
  input  ppd_pkg::alpha_mode_e         alpha_mode_i,
  output ppd_pkg::alpha_info_t         info_o
);

  logic [ppd_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_eff;

  assign cnt_eff = first_pixel_i ? '0 : cnt_q;

  always_comb begin
    info_o.alpha   = ppd_pkg::ALPHA_FULL;
    info_o.advance = 1'b0;
    cnt_d          = cnt_q;
    if (pixel_fire_i) begin
      cnt_d = cnt_eff;
    end
    case (alpha_mode_i)
      ppd_pkg::MODE_BIT: begin
        info_o.alpha   = alpha_byte_i[cnt_eff] ? ppd_pkg::ALPHA_FULL : ppd_pkg::ALPHA_NONE;
        info_o.advance = (cnt_eff == ppd_pkg::CNT_LAST);
        if (pixel_fire_i) begin
          cnt_d = cnt_eff + 1'b1;
        end
      end
      ppd_pkg::MODE_BYTE: begin
        info_o.alpha   = alpha_byte_i;
        info_o.advance = 1'b1;
      end
      default: begin
        info_o.alpha   = ppd_pkg::ALPHA_FULL;
        info_o.advance = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/palette_pixel_decoder_top.sv
// top level of the palette pixel decoder
//
//   port group   direction  contents
//   in_*         in         load or pixel word, valid/ready
//   out_*        out        rgba word with advance flag, valid/ready
//   apb          in/out     alpha mode register at byte address 0
//
// one word per cycle sustained while the output is not stalled; a pixel's result
// passes through the palette ram's registered read and then the output register
// load words write the palette and produce nothing
// reset clears alpha mode, bit counter and valid flags; palette is not cleared
// a stalled output holds one result and one more in the ram stage before in_ready drops
module palette_pixel_decoder_top #(
  parameter int PALETTE_DEPTH = ppd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ppd_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ppd_pkg::out_word_t          out_word_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppd_pkg::APB_AW-1:0]  paddr,
  input  logic [ppd_pkg::APB_DW-1:0]  pwdata,
  output logic [ppd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  ppd_pkg::alpha_mode_e alpha_mode;
  ppd_pkg::alpha_info_t alpha_info;
  ppd_pkg::alpha_info_t s1_alpha_q;
  ppd_pkg::out_word_t   out_word_q, out_word_d;
  logic [ppd_pkg::COLOR_W-1:0] ram_rdata;
  logic s1_valid_q, s1_valid_d, s1_hit_q;
  logic out_valid_q, out_valid_d;
  logic accept, pix_fire, load_fire, in_range, out_free;

  assign in_range  = (int'(in_word_i.palette_index) < PALETTE_DEPTH);
  assign accept    = in_valid_i && in_ready_o;
  assign pix_fire  = accept && (in_word_i.opcode == ppd_pkg::OP_PIXEL);
  assign load_fire = accept && (in_word_i.opcode == ppd_pkg::OP_LOAD) && in_range;
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_free;

  ppd_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .alpha_mode_o (alpha_mode)
  );

  ppd_alpha_gen u_alpha (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_fire_i  (pix_fire),
    .first_pixel_i (in_word_i.first_pixel),
    .alpha_byte_i  (in_word_i.alpha_byte),
    .alpha_mode_i  (alpha_mode),
    .info_o        (alpha_info)
  );

  ppd_ram #(
    .WIDTH (ppd_pkg::COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (in_word_i.palette_index[AW-1:0]),
    .wdata_i (in_word_i.palette_color),
    .re_i    (pix_fire && in_range),
    .raddr_i (in_word_i.palette_index[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_fire) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
      out_word_d.rgba = {s1_alpha_q.alpha,
                         s1_hit_q ? ppd_pkg::swap_rb(ram_rdata) : '0};
      out_word_d.advance_alpha = s1_alpha_q.advance;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      s1_hit_q   <= in_range;
      s1_alpha_q <= alpha_info;
    end
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: design/ppd_checker.sv
// port-level checks for the palette pixel decoder
`include "assert_macros.svh"

module ppd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ppd_pkg::in_word_t   in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ppd_pkg::out_word_t  out_word_o
);

  logic out_stall;
  logic pix_accept;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign pix_accept = in_valid_i && in_ready_o && (in_word_i.opcode == ppd_pkg::OP_PIXEL);

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_word_o))

  `ASSERT_IMP(a_ready_drop, clk_i, rst_ni, !in_ready_o, out_stall)

  `ASSERT_IMP(a_out_origin, clk_i, rst_ni, $rose(out_valid_o), $past(pix_accept, 2))

endmodule

bind palette_pixel_decoder_top ppd_checker u_ppd_checker (.*);
